// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/tiri_pkg.sv =====
// types, constants and codes of the roll interpolator
package tiri_pkg;

    localparam int TIME_W          = 48;
    localparam int ANGLE_W         = 32;
    localparam int IDX_FIELD_W     = 10;
    localparam int CNT_FIELD_W     = 11;
    localparam int STATUS_W        = 2;
    localparam int FRAC_BITS       = 24;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int PROD_W          = ANGLE_W + 2 + FRAC_BITS;
    localparam int STEP_W          = $clog2(FRAC_BITS + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_BEFORE = 2'd1;
    localparam status_t STATUS_AFTER  = 2'd2;
    localparam status_t STATUS_FEW    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_FWD_RD,
        ST_FWD_CHK,
        ST_LERP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]         stamp;
        logic signed [ANGLE_W-1:0] angle;
    } entry_t;

    typedef struct packed {
        logic                      start;
        logic [TIME_W-1:0]         num;
        logic [TIME_W-1:0]         den;
        logic signed [ANGLE_W-1:0] a0;
        logic signed [ANGLE_W-1:0] a1;
    } lerp_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } lerp_rsp_t;

endpackage

// ===== rtl/core/tiri_if.sv =====
// valid/ready channel interfaces for command, result and configuration
interface tiri_cmd_if import tiri_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [IDX_FIELD_W-1:0]    entry_index;
    logic [TIME_W-1:0]         sample_time;
    logic signed [ANGLE_W-1:0] angle_value;

    modport source (output valid, operation, entry_index, sample_time, angle_value,
                    input ready);
    modport sink (input valid, operation, entry_index, sample_time, angle_value,
                  output ready);
endinterface

interface tiri_res_if import tiri_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] interpolated_angle;
    logic [STATUS_W-1:0]       status_code;
    logic [IDX_FIELD_W-1:0]    bin_index;

    modport source (output valid, interpolated_angle, status_code, bin_index,
                    input ready);
    modport sink (input valid, interpolated_angle, status_code, bin_index,
                  output ready);
endinterface

interface tiri_cfg_if import tiri_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CNT_FIELD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/tiri_table.sv =====
// time stamp and angle table, one write and one registered read port
module tiri_table import tiri_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_entry,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_entry
);

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/core/tiri_lerp.sv =====
// serial divide and multiply: one fraction bit per cycle, folded into the product
module tiri_lerp import tiri_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  lerp_req_t req,
    output lerp_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      fin_reg, fin_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [TIME_W-1:0]         rem_reg, rem_next;
    logic [TIME_W-1:0]         den_reg, den_next;
    logic signed [ANGLE_W:0]   diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ANGLE_W-1:0] a0_reg, a0_next;

    logic signed [ANGLE_W:0]   diff_start;
    logic [TIME_W:0]           rem_dbl;
    logic                      qbit;
    logic [PROD_W-FRAC_BITS-1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        a0_reg   <= a0_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        a0_next    = a0_reg;
        diff_start = {req.a1[ANGLE_W-1], req.a1} - {req.a0[ANGLE_W-1], req.a0};
        rem_dbl    = {rem_reg, 1'b0};
        qbit       = (rem_dbl >= {1'b0, den_reg});

        if (req.start)
        begin
            a0_next   = req.a0;
            diff_next = diff_start;
            den_next  = req.den;
            if (req.num >= req.den)
            begin
                // time at the upper edge: fraction is exactly one
                prod_next = PROD_W'(diff_start) <<< FRAC_BITS;
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                rem_next  = req.num;
                prod_next = '0;
                step_next = STEP_W'(FRAC_BITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (qbit)
            begin
                rem_next  = TIME_W'(rem_dbl - {1'b0, den_reg});
                prod_next = (prod_reg <<< 1) + PROD_W'(diff_reg);
            end
            else
            begin
                rem_next  = rem_dbl[TIME_W-1:0];
                prod_next = prod_reg <<< 1;
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    // arithmetic shift of the product floors toward minus infinity
    assign sum = {{(PROD_W - FRAC_BITS - ANGLE_W){a0_reg[ANGLE_W-1]}}, a0_reg}
               + prod_reg[PROD_W-1:FRAC_BITS];

    assign rsp.done  = fin_reg;
    assign rsp.angle = sum[ANGLE_W-1:0];

endmodule

// ===== rtl/core/time_indexed_roll_interpolator_core.sv =====
// top level: table walk sequencer, serial interpolation and result register
// A load item writes one table entry (if its index lies inside the table) and its result
// is ready the next cycle. A query walks the cursor one entry at a time (one table read and
// one compare per step), first back and then forward, through the single read port of the
// table; once the bin is found the fraction and the product come out of a bit-serial unit,
// one fraction bit per cycle. Errors and zero-width bins skip the serial unit, and a time
// on the upper edge of the bin passes it without the bit-serial steps. One item is in work
// at a time, and a new item is taken only once the result register is free or being emptied.
// The configuration write (entries_in_use) is always ready and is meant for idle periods.
module time_indexed_roll_interpolator_core import tiri_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tiri_cfg_if.sink   cfg,
    tiri_cmd_if.sink   cmd,
    tiri_res_if.source res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int N_W   = $clog2(TABLE_DEPTH + 1);

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          cursor_reg, cursor_next;
    logic [IDX_W-1:0]          last_reg, last_next;
    logic [TIME_W-1:0]         tq_reg, tq_next;
    logic [TIME_W-1:0]         t0_reg, t0_next;
    logic signed [ANGLE_W-1:0] a0_reg, a0_next;
    status_t                   status_reg, status_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic [CNT_FIELD_W-1:0]    entries_reg;

    logic                      res_valid_reg, res_valid_next;
    logic signed [ANGLE_W-1:0] res_angle_reg, res_angle_next;
    status_t                   res_status_reg, res_status_next;
    logic [IDX_FIELD_W-1:0]    res_bin_reg, res_bin_next;

    logic [N_W-1:0]            n_lim;
    logic [IDX_W-1:0]          last_idx;
    logic                      out_free;
    logic                      cmd_acc;
    logic                      wr_en;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    entry_t                    wr_entry;
    entry_t                    rd_entry;
    lerp_req_t                 lerp_req;
    lerp_rsp_t                 lerp_rsp;

    always_comb
    begin
        if (32'(entries_reg) > TABLE_DEPTH)
        begin
            n_lim = N_W'(TABLE_DEPTH);
        end
        else
        begin
            n_lim = N_W'(entries_reg);
        end
    end

    assign last_idx  = IDX_W'(n_lim - N_W'(2));
    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign wr_en          = cmd_acc && (cmd.operation == OP_LOAD)
                          && (32'(cmd.entry_index) < TABLE_DEPTH);
    assign wr_entry.stamp = cmd.sample_time;
    assign wr_entry.angle = cmd.angle_value;
    assign rd_en          = (state_reg == ST_BACK_RD) || (state_reg == ST_FWD_RD);
    assign rd_addr        = (state_reg == ST_FWD_RD) ? cursor_reg + IDX_W'(1) : cursor_reg;

    tiri_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (IDX_W'(cmd.entry_index)),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    tiri_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .rsp   (lerp_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            entries_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                entries_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        tq_reg         <= tq_next;
        t0_reg         <= t0_next;
        a0_reg         <= a0_next;
        status_reg     <= status_next;
        angle_reg      <= angle_next;
        res_angle_reg  <= res_angle_next;
        res_status_reg <= res_status_next;
        res_bin_reg    <= res_bin_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        last_next       = last_reg;
        tq_next         = tq_reg;
        t0_next         = t0_reg;
        a0_next         = a0_reg;
        status_next     = status_reg;
        angle_next      = angle_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_angle_next  = res_angle_reg;
        res_status_next = res_status_reg;
        res_bin_next    = res_bin_reg;
        lerp_req.start  = 1'b0;
        lerp_req.num    = tq_reg - t0_reg;
        lerp_req.den    = rd_entry.stamp - t0_reg;
        lerp_req.a0     = a0_reg;
        lerp_req.a1     = rd_entry.angle;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if ((cmd.operation == OP_LOAD) || (n_lim < N_W'(2)))
                    begin
                        res_valid_next  = 1'b1;
                        res_angle_next  = '0;
                        res_status_next = (cmd.operation == OP_LOAD) ? STATUS_OK : STATUS_FEW;
                        res_bin_next    = IDX_FIELD_W'(cursor_reg);
                    end
                    else
                    begin
                        cursor_next = (cursor_reg > last_idx) ? last_idx : cursor_reg;
                        last_next   = last_idx;
                        tq_next     = cmd.sample_time;
                        status_next = STATUS_OK;
                        angle_next  = '0;
                        state_next  = ST_BACK_RD;
                    end
                end
            end
            ST_BACK_RD:
            begin
                state_next = ST_BACK_CHK;
            end
            ST_BACK_CHK:
            begin
                t0_next = rd_entry.stamp;
                a0_next = rd_entry.angle;
                if (tq_reg < rd_entry.stamp)
                begin
                    if (cursor_reg == '0)
                    begin
                        status_next = STATUS_BEFORE;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - IDX_W'(1);
                        state_next  = ST_BACK_RD;
                    end
                end
                else
                begin
                    state_next = ST_FWD_RD;
                end
            end
            ST_FWD_RD:
            begin
                state_next = ST_FWD_CHK;
            end
            ST_FWD_CHK:
            begin
                if (tq_reg > rd_entry.stamp)
                begin
                    if (cursor_reg >= last_reg)
                    begin
                        status_next = STATUS_AFTER;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // upper entry becomes the lower one of the next bin
                        cursor_next = cursor_reg + IDX_W'(1);
                        t0_next     = rd_entry.stamp;
                        a0_next     = rd_entry.angle;
                        state_next  = ST_FWD_RD;
                    end
                end
                else if (rd_entry.stamp <= t0_reg)
                begin
                    // zero-width bin
                    angle_next = a0_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    lerp_req.start = 1'b1;
                    state_next     = ST_LERP;
                end
            end
            ST_LERP:
            begin
                if (lerp_rsp.done)
                begin
                    angle_next = lerp_rsp.angle;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_angle_next  = angle_reg;
                    res_status_next = status_reg;
                    res_bin_next    = IDX_FIELD_W'(cursor_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid              = res_valid_reg;
    assign res.interpolated_angle = res_angle_reg;
    assign res.status_code        = res_status_reg;
    assign res.bin_index          = res_bin_reg;

endmodule

// ===== rtl/core/tiri_checker.sv =====
// port-level checks of the roll interpolator and their bind
`include "assert_macros.svh"

module tiri_checker import tiri_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cmd_valid,
    input logic                   cmd_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [ANGLE_W-1:0]     res_angle,
    input logic [STATUS_W-1:0]    res_status,
    input logic [IDX_FIELD_W-1:0] res_bin
);

    // a pending result is not dropped
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // no item is taken while a result is stuck in the output register
    `ASSERT_IMPLIES(a_no_accept_stalled, clk, rst_n, cmd_valid && cmd_ready, !res_valid || res_ready)

    // every error status carries a zero angle
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, res_valid && (res_status != STATUS_OK), res_angle == '0)

    // running off the front leaves the cursor at the first bin
    `ASSERT_IMPLIES(a_before_bin, clk, rst_n, res_valid && (res_status == STATUS_BEFORE), res_bin == '0)

endmodule

bind time_indexed_roll_interpolator_core tiri_checker u_tiri_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_angle  (res.interpolated_angle),
    .res_status (res.status_code),
    .res_bin    (res.bin_index)
);
